FILE: rtl/ffba_pkg.sv
// Package for the first-fit block allocator: request and response structs,
// status, command and register codes. No dependencies.
`default_nettype none

package ffba_pkg;

    localparam int unsigned FIELD_BITS = 32;

    // Commands
    localparam logic CMD_ALLOC  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_BASE_ADDRESS = 1'b0;
    localparam logic CFG_CAPACITY     = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] request_size;
        logic [31:0] lookup_address;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] block_address;
        logic [5:0]  block_index;
        logic [6:0]  busy_blocks;
    } t_rsp;

endpackage

`default_nettype wire

FILE: rtl/first_fit_block_allocator_core.sv
// First-fit block allocator top level: request/response handshakes,
// configuration registers, scan controller. Uses ffba_pkg and ffba_ram.
//
// Usage:
//   Requests come in on i_in_valid/o_in_ready with an ffba_pkg::t_req payload
//   (allocate or lookup). Each request yields exactly one response on
//   o_out_valid/i_out_ready (ffba_pkg::t_rsp). Registers base_address (index 0)
//   and capacity (index 1) are to be written through i_cfg_we/i_cfg_idx/i_cfg_data
//   only while the block is idle; the block itself does not enforce this.
//   The block table lives in one RAM with a registered read. A request walks
//   the table one entry per cycle from index 0 until the first match. Its
//   steps in order: latch, space or range check, the scan, up to two RAM
//   writes for split and mark, and loading the output register. One request
//   is in work at a time.
//   Reset (synchronous, active low) empties the table, zeroes both counters
//   and both registers; no clearing pass is needed since only entries below
//   the fill count are ever read.
//   A response waits in the output register while i_out_ready is low; the
//   next request may be accepted meanwhile, but its result holds until the
//   register frees.
`default_nettype none

module first_fit_block_allocator_core #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned ADDR_BITS     = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire ffba_pkg::t_req i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output ffba_pkg::t_rsp     o_out,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_idx,
    input  wire logic [31:0]   i_cfg_data
);

    import ffba_pkg::*;

    localparam int unsigned IW   = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNTW = IW + 1;
    localparam int unsigned CW   = (ADDR_BITS > 32) ? ADDR_BITS : 32;
    localparam int unsigned EW   = ADDR_BITS + 33;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_HIT   = 3'd3;
    localparam logic [2:0] S_MARK  = 3'd4;
    localparam logic [2:0] S_NOFIT = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]           r_state, n_state;
    logic                 r_cmd, n_cmd;
    logic [31:0]          r_size, n_size;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [ADDR_BITS-1:0] r_used, n_used;
    logic [CNTW-1:0]      r_rd_idx, n_rd_idx;
    logic                 r_pend, n_pend;
    logic [IW-1:0]        r_pend_idx, n_pend_idx;
    logic [ADDR_BITS-1:0] r_hit_addr, n_hit_addr;
    logic [31:0]          r_hit_size, n_hit_size;
    logic [IW-1:0]        r_hit_idx, n_hit_idx;
    logic [1:0]           r_res_status, n_res_status;
    logic [31:0]          r_res_addr, n_res_addr;
    logic [IW-1:0]        r_res_idx, n_res_idx;
    logic                 r_out_valid, n_out_valid;
    t_rsp                 r_out, n_out;
    logic [ADDR_BITS-1:0] r_base, n_base;
    logic [31:0]          r_cap, n_cap;
    logic [ADDR_BITS-1:0] r_heap_end, n_heap_end;
    logic [CNTW-1:0]      r_entry_count, n_entry_count;
    logic [CNTW-1:0]      r_busy_count, n_busy_count;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic                 ram_re;
    logic [IW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;

    logic [ADDR_BITS-1:0] e_addr;
    logic [31:0]          e_size;
    logic                 e_busy;
    logic                 e_match;
    logic                 table_full;
    logic [CW-1:0]        used_w;
    logic [CW-1:0]        cap_w;
    logic [CW-1:0]        size_w;
    logic                 no_space;

    ffba_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign e_addr = ram_rdata[ADDR_BITS-1:0];
    assign e_size = ram_rdata[ADDR_BITS+31:ADDR_BITS];
    assign e_busy = ram_rdata[EW-1];

    assign e_match = (r_cmd == CMD_ALLOC) ? (!e_busy && (e_size >= r_size))
                                          : (e_busy && (e_addr == r_addr));

    assign table_full = (r_entry_count == CNTW'(TABLE_ENTRIES));

    // Room left is zero once the heap overran capacity; a zero-size request still fits.
    assign used_w   = CW'(r_used);
    assign cap_w    = CW'(r_cap);
    assign size_w   = CW'(r_size);
    assign no_space = (used_w > cap_w) ? (size_w != '0) : (size_w > (cap_w - used_w));

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_size        = r_size;
        n_addr        = r_addr;
        n_used        = r_used;
        n_rd_idx      = r_rd_idx;
        n_pend        = r_pend;
        n_pend_idx    = r_pend_idx;
        n_hit_addr    = r_hit_addr;
        n_hit_size    = r_hit_size;
        n_hit_idx     = r_hit_idx;
        n_res_status  = r_res_status;
        n_res_addr    = r_res_addr;
        n_res_idx     = r_res_idx;
        n_out         = r_out;
        n_base        = r_base;
        n_cap         = r_cap;
        n_heap_end    = r_heap_end;
        n_entry_count = r_entry_count;
        n_busy_count  = r_busy_count;
        n_out_valid   = r_out_valid && !i_out_ready;

        ram_we    = 1'b0;
        ram_waddr = r_entry_count[IW-1:0];
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_rd_idx[IW-1:0];

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_BASE_ADDRESS: begin
                    n_base = ADDR_BITS'(i_cfg_data);
                    if (r_entry_count == '0) begin
                        n_heap_end = ADDR_BITS'(i_cfg_data);
                    end
                end
                CFG_CAPACITY: begin
                    n_cap = i_cfg_data;
                end
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in.cmd;
                    n_size  = i_in.request_size;
                    n_addr  = ADDR_BITS'(i_in.lookup_address);
                    n_used  = r_heap_end - r_base;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_rd_idx = '0;
                n_pend   = 1'b0;
                n_state  = S_SCAN;
                if (r_cmd == CMD_ALLOC) begin
                    if (no_space) begin
                        n_res_status = ST_NO_SPACE;
                        n_state      = S_DONE;
                    end
                end else if ((r_addr < r_base) || (r_addr > r_heap_end)) begin
                    n_res_status = ST_NOT_FOUND;
                    n_state      = S_DONE;
                end
            end
            S_SCAN: begin
                // Reads run one ahead of the compare; stop on the first match.
                if (r_pend && e_match) begin
                    n_hit_addr = e_addr;
                    n_hit_size = e_size;
                    n_hit_idx  = r_pend_idx;
                    n_pend     = 1'b0;
                    n_state    = S_HIT;
                end else if (r_rd_idx < r_entry_count) begin
                    ram_re     = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_rd_idx[IW-1:0];
                    n_rd_idx   = r_rd_idx + CNTW'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_NOFIT;
                end
            end
            S_HIT: begin
                n_res_addr = 32'(r_hit_addr);
                n_res_idx  = r_hit_idx;
                n_state    = S_DONE;
                if (r_cmd == CMD_LOOKUP) begin
                    n_res_status = ST_OK;
                end else if (r_hit_size == r_size) begin
                    ram_we       = 1'b1;
                    ram_waddr    = r_hit_idx;
                    ram_wdata    = {1'b1, r_hit_size, r_hit_addr};
                    n_busy_count = r_busy_count + CNTW'(1);
                    n_res_status = ST_OK;
                end else if (table_full) begin
                    n_res_status = ST_TABLE_FULL;
                end else begin
                    // Append the free remainder, then shrink the hit entry.
                    ram_we        = 1'b1;
                    ram_waddr     = r_entry_count[IW-1:0];
                    ram_wdata     = {1'b0, r_hit_size - r_size,
                                     r_hit_addr + ADDR_BITS'(r_size)};
                    n_entry_count = r_entry_count + CNTW'(1);
                    n_state       = S_MARK;
                end
            end
            S_MARK: begin
                ram_we       = 1'b1;
                ram_waddr    = r_hit_idx;
                ram_wdata    = {1'b1, r_size, r_hit_addr};
                n_busy_count = r_busy_count + CNTW'(1);
                n_res_status = ST_OK;
                n_state      = S_DONE;
            end
            S_NOFIT: begin
                n_state = S_DONE;
                if (r_cmd == CMD_LOOKUP) begin
                    n_res_status = ST_NOT_FOUND;
                end else if (table_full) begin
                    n_res_status = ST_TABLE_FULL;
                end else begin
                    ram_we        = 1'b1;
                    ram_waddr     = r_entry_count[IW-1:0];
                    ram_wdata     = {1'b1, r_size, r_heap_end};
                    n_res_addr    = 32'(r_heap_end);
                    n_res_idx     = r_entry_count[IW-1:0];
                    n_entry_count = r_entry_count + CNTW'(1);
                    n_heap_end    = r_heap_end + ADDR_BITS'(r_size);
                    n_busy_count  = r_busy_count + CNTW'(1);
                    n_res_status  = ST_OK;
                end
            end
            S_DONE: begin
                // Hold until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid         = 1'b1;
                    n_out.status        = r_res_status;
                    n_out.block_address = (r_res_status == ST_OK) ? r_res_addr : '0;
                    n_out.block_index   = (r_res_status == ST_OK) ? 6'(r_res_idx) : '0;
                    n_out.busy_blocks   = 7'(r_busy_count);
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_pend        <= 1'b0;
            r_out_valid   <= 1'b0;
            r_base        <= '0;
            r_cap         <= '0;
            r_heap_end    <= '0;
            r_entry_count <= '0;
            r_busy_count  <= '0;
        end else begin
            r_state       <= n_state;
            r_pend        <= n_pend;
            r_out_valid   <= n_out_valid;
            r_base        <= n_base;
            r_cap         <= n_cap;
            r_heap_end    <= n_heap_end;
            r_entry_count <= n_entry_count;
            r_busy_count  <= n_busy_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_size       <= n_size;
        r_addr       <= n_addr;
        r_used       <= n_used;
        r_rd_idx     <= n_rd_idx;
        r_pend_idx   <= n_pend_idx;
        r_hit_addr   <= n_hit_addr;
        r_hit_size   <= n_hit_size;
        r_hit_idx    <= n_hit_idx;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_res_idx    <= n_res_idx;
        r_out        <= n_out;
    end

    a_busy_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy_count <= r_entry_count)
        else $error("busy count exceeds entry count");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state != S_SCAN))
        else $error("table write during scan");

    a_count_holds_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_entry_count == CNTW'(TABLE_ENTRIES)) |=> (r_entry_count == CNTW'(TABLE_ENTRIES)))
        else $error("entry count moved past a full table");

    a_pend_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_SCAN))
        else $error("read pending outside scan");

endmodule

`default_nettype wire

FILE: rtl/ffba_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none

module ffba_ram #(
    parameter int unsigned WIDTH = 65,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
